@@ hw/rtl/crfa_pkg.sv @@
// Shared types and constants for the contiguous ring frame allocator.
package crfa_pkg;

  localparam int unsigned BODY_W    = 18;
  localparam int unsigned POS_OUT_W = 17;
  localparam int unsigned LEN_W     = 18;
  localparam int unsigned HDR_W     = 4;
  localparam int unsigned FULL_W    = 19;

  localparam int unsigned SMALL_LIMIT  = 126;
  localparam int unsigned MEDIUM_LIMIT = 65536;
  localparam int unsigned MARKER_BODY  = 9;
  localparam int unsigned HDR_SMALL    = 2;
  localparam int unsigned HDR_MEDIUM   = 4;
  localparam int unsigned HDR_LARGE    = 10;
  localparam int unsigned MARKER_FULL  = MARKER_BODY + HDR_SMALL;

  typedef enum logic [1:0] {
    KIND_RESERVE,
    KIND_QUERY,
    KIND_SENT,
    KIND_DROP
  } crfa_kind_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_NORM,
    CMD_PLACE_FRAME,
    CMD_PLACE_MARK,
    CMD_RUN,
    CMD_SENT,
    CMD_DROP,
    CMD_EMIT
  } crfa_cmd_e;

  typedef struct packed {
    crfa_kind_e kind;
    logic       place_ok;
    logic       last_ovr;
    logic       out_free;
  } crfa_stat_t;

endpackage

@@ hw/rtl/crfa_datapath.sv @@
// Datapath of the ring allocator: pointers, placement check, result registers.
module crfa_datapath import crfa_pkg::*; #(
  parameter int unsigned BUF_BYTES = 131072
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crfa_cmd_e            cmd_i,
  output crfa_stat_t           stat_o,
  input  logic [1:0]           kind_i,
  input  logic [BODY_W-1:0]    body_len_i,
  input  logic [BODY_W-1:0]    sent_count_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 accepted_o,
  output logic [POS_OUT_W-1:0] frame_start_o,
  output logic [HDR_W-1:0]     header_len_o,
  output logic                 overrun_written_o,
  output logic [POS_OUT_W-1:0] overrun_start_o,
  output logic [LEN_W-1:0]     lost_len_o,
  output logic [POS_OUT_W-1:0] run_start_o,
  output logic [LEN_W-1:0]     run_len_o
);

  localparam int unsigned PW = $clog2(BUF_BYTES + 1);
  localparam int unsigned CW = (PW > FULL_W) ? PW : FULL_W;

  // allocator state
  logic [PW-1:0] write_q, wrap_q, read_q, run_q;
  logic          lwo_q;
  // captured request
  crfa_kind_e        kind_q;
  logic [BODY_W-1:0] sent_q;
  logic [FULL_W-1:0] full_q, need_q;
  logic [HDR_W-1:0]  hlen_q;
  // result in progress
  logic              acc_q, ow_q;
  logic [CW-1:0]     fstart_q, ostart_q;
  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 acc_out_q, ow_out_q;
  logic [POS_OUT_W-1:0] fstart_out_q, ostart_out_q, rstart_out_q;
  logic [HDR_W-1:0]     hlen_out_q;
  logic [LEN_W-1:0]     lost_out_q, rlen_out_q;

  logic [CW-1:0]     wr_x, rd_x, wrap_x, buf_x, size_x, need_x, run_x, sent_x, step_x;
  logic              fit_lin, fit_end, fit_wrap, place_ok;
  logic [CW-1:0]     place_start, write_next;
  logic [PW-1:0]     run_len;
  logic              norm_hit;
  logic [HDR_W-1:0]  hlen_new;
  logic [FULL_W-1:0] full_new;

  assign wr_x   = CW'(write_q);
  assign rd_x   = CW'(read_q);
  assign wrap_x = CW'(wrap_q);
  assign buf_x  = CW'(BUF_BYTES);
  assign run_x  = CW'(run_q);
  assign sent_x = CW'(sent_q);

  // marker placement needs exactly its own size, no spare
  always_comb begin
    if (cmd_i == CMD_PLACE_MARK) begin
      size_x = CW'(MARKER_FULL);
      need_x = CW'(MARKER_FULL);
    end else begin
      size_x = CW'(full_q);
      need_x = CW'(need_q);
    end
  end

  always_comb begin
    fit_lin  = (wr_x < rd_x) && (need_x < rd_x - wr_x);
    fit_end  = !(wr_x < rd_x) && (wr_x <= buf_x) && (need_x <= buf_x - wr_x);
    fit_wrap = !(wr_x < rd_x) && !fit_end && (need_x < rd_x);
    place_ok = fit_lin || fit_end || fit_wrap;
    place_start = fit_wrap ? '0 : wr_x;
    write_next  = fit_wrap ? size_x : wr_x + size_x;
  end

  always_comb begin
    if (read_q == write_q) begin
      run_len = '0;
    end else if (read_q < write_q) begin
      run_len = write_q - read_q;
    end else if (wrap_q > read_q) begin
      run_len = wrap_q - read_q;
    end else begin
      run_len = '0;
    end
  end

  assign norm_hit = (read_q > write_q) && (rd_x >= wrap_x);
  assign step_x   = (sent_x > run_x) ? run_x : sent_x;

  always_comb begin
    if (body_len_i < BODY_W'(SMALL_LIMIT)) begin
      hlen_new = HDR_W'(HDR_SMALL);
    end else if (body_len_i < BODY_W'(MEDIUM_LIMIT)) begin
      hlen_new = HDR_W'(HDR_MEDIUM);
    end else begin
      hlen_new = HDR_W'(HDR_LARGE);
    end
    full_new = FULL_W'(body_len_i) + FULL_W'(hlen_new);
  end

  // a new result may replace one that leaves in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i == CMD_EMIT) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_q     <= '0;
      wrap_q      <= '0;
      read_q      <= '0;
      lwo_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (cmd_i)
        CMD_NORM: begin
          if (norm_hit) begin
            read_q <= '0;
          end
        end
        CMD_PLACE_FRAME: begin
          if (place_ok) begin
            write_q <= PW'(write_next);
            lwo_q   <= 1'b0;
            if (fit_wrap) begin
              wrap_q <= write_q;
            end
          end
        end
        CMD_PLACE_MARK: begin
          if (place_ok) begin
            write_q <= PW'(write_next);
            lwo_q   <= 1'b1;
            if (fit_wrap) begin
              wrap_q <= write_q;
            end
          end
        end
        CMD_SENT: begin
          read_q <= PW'(rd_x + step_x);
        end
        CMD_DROP: begin
          read_q <= write_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        kind_q   <= crfa_kind_e'(kind_i);
        sent_q   <= sent_count_i;
        hlen_q   <= hlen_new;
        full_q   <= full_new;
        need_q   <= full_new + FULL_W'(MARKER_FULL);
        acc_q    <= 1'b0;
        ow_q     <= 1'b0;
        fstart_q <= '0;
        ostart_q <= '0;
      end
      CMD_PLACE_FRAME: begin
        if (place_ok) begin
          acc_q    <= 1'b1;
          fstart_q <= place_start;
        end
      end
      CMD_PLACE_MARK: begin
        if (place_ok) begin
          ow_q     <= 1'b1;
          ostart_q <= place_start;
        end
      end
      CMD_RUN: begin
        run_q <= run_len;
      end
      CMD_EMIT: begin
        acc_out_q    <= acc_q;
        fstart_out_q <= fstart_q[POS_OUT_W-1:0];
        hlen_out_q   <= (kind_q == KIND_RESERVE) ? hlen_q : '0;
        ow_out_q     <= ow_q;
        ostart_out_q <= ostart_q[POS_OUT_W-1:0];
        lost_out_q   <= ow_q ? full_q[LEN_W-1:0] : '0;
        rstart_out_q <= rd_x[POS_OUT_W-1:0];
        rlen_out_q   <= run_x[LEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.place_ok = place_ok;
  assign stat_o.last_ovr = lwo_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_out_q;
  assign frame_start_o     = fstart_out_q;
  assign header_len_o      = hlen_out_q;
  assign overrun_written_o = ow_out_q;
  assign overrun_start_o   = ostart_out_q;
  assign lost_len_o        = lost_out_q;
  assign run_start_o       = rstart_out_q;
  assign run_len_o         = rlen_out_q;

endmodule

@@ hw/rtl/crfa_ctrl.sv @@
// Ring allocator step sequencer: one datapath command per cycle unless emit stalls.
module crfa_ctrl import crfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  crfa_stat_t stat_i,
  output crfa_cmd_e  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM0,
    ST_PLACE,
    ST_NORM1,
    ST_MARK,
    ST_RUN0,
    ST_SENT,
    ST_DROP,
    ST_NORM2,
    ST_RUN2,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_NORM0;
        end
      end
      ST_NORM0: begin
        cmd_o = CMD_NORM;
        case (stat_i.kind)
          KIND_RESERVE: state_d = ST_PLACE;
          KIND_SENT:    state_d = ST_RUN0;
          KIND_DROP:    state_d = ST_DROP;
          default:      state_d = ST_RUN2;
        endcase
      end
      ST_PLACE: begin
        cmd_o = CMD_PLACE_FRAME;
        // on failure, try the marker unless one was the last frame placed
        if (!stat_i.place_ok && !stat_i.last_ovr) begin
          state_d = ST_NORM1;
        end else begin
          state_d = ST_NORM2;
        end
      end
      ST_NORM1: begin
        cmd_o   = CMD_NORM;
        state_d = ST_MARK;
      end
      ST_MARK: begin
        cmd_o   = CMD_PLACE_MARK;
        state_d = ST_NORM2;
      end
      ST_RUN0: begin
        cmd_o   = CMD_RUN;
        state_d = ST_SENT;
      end
      ST_SENT: begin
        cmd_o   = CMD_SENT;
        state_d = ST_NORM2;
      end
      ST_DROP: begin
        cmd_o   = CMD_DROP;
        state_d = ST_NORM2;
      end
      ST_NORM2: begin
        cmd_o   = CMD_NORM;
        state_d = ST_RUN2;
      end
      ST_RUN2: begin
        cmd_o   = CMD_RUN;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register frees up
        if (stat_i.out_free) begin
          cmd_o   = CMD_EMIT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/contiguous_ring_frame_allocator.sv @@
// Top level of the contiguous ring frame allocator.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  in      | in_valid_i/in_ready_o  | kind_i, body_len_i, sent_count_i
//  out     | out_valid_o/out_ready_i| accepted_o .. run_len_o (one per transaction)
//
// Per transaction: normalise; reserve places the frame, else (unless a marker was
// last) normalises and places a marker; sent measures the run and moves the reader;
// drop moves it to the writer; non-queries renormalise; all measure, emit, then idle.
// Reset clears all pointers and the overrun flag; the block is ready at once.
// A finished result waits in the output register while the next transaction
// is accepted and worked on; only its emit step stalls on a busy output.
module contiguous_ring_frame_allocator import crfa_pkg::*; #(
  parameter int unsigned BUF_BYTES = 131072
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [BODY_W-1:0]    body_len_i,
  input  logic [BODY_W-1:0]    sent_count_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 accepted_o,
  output logic [POS_OUT_W-1:0] frame_start_o,
  output logic [HDR_W-1:0]     header_len_o,
  output logic                 overrun_written_o,
  output logic [POS_OUT_W-1:0] overrun_start_o,
  output logic [LEN_W-1:0]     lost_len_o,
  output logic [POS_OUT_W-1:0] run_start_o,
  output logic [LEN_W-1:0]     run_len_o
);

  crfa_cmd_e  cmd;
  crfa_stat_t stat;

  crfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crfa_datapath #(
    .BUF_BYTES (BUF_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .kind_i            (kind_i),
    .body_len_i        (body_len_i),
    .sent_count_i      (sent_count_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .accepted_o        (accepted_o),
    .frame_start_o     (frame_start_o),
    .header_len_o      (header_len_o),
    .overrun_written_o (overrun_written_o),
    .overrun_start_o   (overrun_start_o),
    .lost_len_o        (lost_len_o),
    .run_start_o       (run_start_o),
    .run_len_o         (run_len_o)
  );

endmodule

@@ sim/crfa_result_checker.sv @@
// Checker that predicts and compares allocator results on the two channels.
`timescale 1ns / 1ps

module crfa_result_checker import crfa_pkg::*; #(
  parameter int unsigned BUF_BYTES = 131072
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           kind_i,
  input  logic [BODY_W-1:0]    body_len_i,
  input  logic [BODY_W-1:0]    sent_count_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 accepted_i,
  input  logic [POS_OUT_W-1:0] frame_start_i,
  input  logic [HDR_W-1:0]     header_len_i,
  input  logic                 overrun_written_i,
  input  logic [POS_OUT_W-1:0] overrun_start_i,
  input  logic [LEN_W-1:0]     lost_len_i,
  input  logic [POS_OUT_W-1:0] run_start_i,
  input  logic [LEN_W-1:0]     run_len_i,
  output int unsigned          fail_count_o,
  output int unsigned          outstanding_o
);

  localparam int unsigned DUE_DEPTH = 8;

  typedef struct {
    logic                 accepted;
    logic [POS_OUT_W-1:0] frame_start;
    logic [HDR_W-1:0]     header_len;
    logic                 overrun_written;
    logic [POS_OUT_W-1:0] overrun_start;
    logic [LEN_W-1:0]     lost_len;
    logic [POS_OUT_W-1:0] run_start;
    logic [LEN_W-1:0]     run_len;
  } alloc_reply_t;

  // Ring pointers as the block keeps them
  logic [LEN_W-1:0] wr_pos;
  logic [LEN_W-1:0] wrap_at;
  logic [LEN_W-1:0] rd_pos;
  logic             last_marker;

  // Expected results in order, as a small ring
  alloc_reply_t replies_due[DUE_DEPTH];
  logic [2:0]   due_head;
  int unsigned  due_count = 0;
  int unsigned  fail_cnt = 0;

  // Move the reader back to 0 once it has consumed up to the wrap point.
  function automatic void wrap_read();
    if (rd_pos > wr_pos && rd_pos >= wrap_at) rd_pos = '0;
  endfunction

  function automatic int unsigned pending_run();
    if (rd_pos == wr_pos) return 0;
    if (rd_pos < wr_pos) return 32'(wr_pos - rd_pos);
    return (wrap_at > rd_pos) ? 32'(wrap_at - rd_pos) : 0;
  endfunction

  function automatic bit claim_space(input int unsigned size, input int unsigned spare,
                                     output int unsigned at);
    int unsigned need;
    need = size + spare;
    at   = 0;
    if (wr_pos < rd_pos) begin
      if (need < rd_pos - wr_pos) begin
        at     = 32'(wr_pos);
        wr_pos = LEN_W'(wr_pos + size);
        return 1'b1;
      end
    end else begin
      if (wr_pos <= BUF_BYTES && need <= BUF_BYTES - wr_pos) begin
        at     = 32'(wr_pos);
        wr_pos = LEN_W'(wr_pos + size);
        return 1'b1;
      end
      // No room at the tail: restart at 0 and remember where the data ends
      if (need < rd_pos) begin
        wrap_at = wr_pos;
        wr_pos  = LEN_W'(size);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_reply_t serve_request(input crfa_kind_e kind,
                                                 input int unsigned body,
                                                 input int unsigned sent);
    alloc_reply_t r;
    int unsigned  hdr;
    int unsigned  full;
    int unsigned  at;
    int unsigned  avail;
    r = '{default: '0};
    wrap_read();
    case (kind)
      KIND_RESERVE: begin
        hdr  = (body < SMALL_LIMIT) ? HDR_SMALL : (body < MEDIUM_LIMIT) ? HDR_MEDIUM : HDR_LARGE;
        full = body + hdr;
        r.header_len = HDR_W'(hdr);
        if (claim_space(full, MARKER_FULL, at)) begin
          r.accepted    = 1'b1;
          r.frame_start = POS_OUT_W'(at);
          last_marker   = 1'b0;
        end else if (!last_marker) begin
          wrap_read();
          if (claim_space(MARKER_FULL, 0, at)) begin
            r.overrun_written = 1'b1;
            r.overrun_start   = POS_OUT_W'(at);
            r.lost_len        = LEN_W'(full);
            last_marker       = 1'b1;
          end
        end
      end
      KIND_SENT: begin
        avail = pending_run();
        if (sent > avail) sent = avail;
        rd_pos = LEN_W'(rd_pos + sent);
      end
      KIND_DROP: rd_pos = wr_pos;
      default: ;
    endcase
    wrap_read();
    r.run_start = rd_pos[POS_OUT_W-1:0];
    r.run_len   = LEN_W'(pending_run());
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", label, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    alloc_reply_t want;
    if (!rst_ni) begin
      wr_pos      = '0;
      wrap_at     = '0;
      rd_pos      = '0;
      last_marker = 1'b0;
      due_head    = '0;
      due_count   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_count == 0) begin
          $error("result transaction with no request outstanding");
          fail_cnt++;
        end else begin
          want      = replies_due[due_head];
          due_head  = due_head + 3'd1;
          due_count = due_count - 1;
          check_field("accepted", want.accepted, accepted_i);
          check_field("frame_start", want.frame_start, frame_start_i);
          check_field("header_len", want.header_len, header_len_i);
          check_field("overrun_written", want.overrun_written, overrun_written_i);
          check_field("overrun_start", want.overrun_start, overrun_start_i);
          check_field("lost_len", want.lost_len, lost_len_i);
          check_field("run_start", want.run_start, run_start_i);
          check_field("run_len", want.run_len, run_len_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (due_count == DUE_DEPTH) begin
          $error("more requests outstanding than the checker holds");
          fail_cnt++;
        end else begin
          replies_due[due_head + 3'(due_count)] =
            serve_request(crfa_kind_e'(kind_i), 32'(body_len_i), 32'(sent_count_i));
          due_count = due_count + 1;
        end
      end
    end
    outstanding_o <= due_count;
    fail_count_o  <= fail_cnt;
  end

endmodule

@@ sim/contiguous_ring_frame_allocator_tb.sv @@
// Testbench top: request stimulus, result back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module contiguous_ring_frame_allocator_tb;
  import crfa_pkg::*;

  localparam int unsigned BUF_BYTES    = 131072;
  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_AT      = 3000;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned CALM_FROM    = 6000;
  localparam int unsigned CALM_TO      = 8000;
  localparam int unsigned BODY_MAX     = 131072;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  crfa_kind_e           req_kind;
  logic [BODY_W-1:0]    body_len_i;
  logic [BODY_W-1:0]    sent_count_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 accepted_o;
  logic [POS_OUT_W-1:0] frame_start_o;
  logic [HDR_W-1:0]     header_len_o;
  logic                 overrun_written_o;
  logic [POS_OUT_W-1:0] overrun_start_o;
  logic [LEN_W-1:0]     lost_len_o;
  logic [POS_OUT_W-1:0] run_start_o;
  logic [LEN_W-1:0]     run_len_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned idle_cycles  = 0;
  int unsigned results_seen = 0;
  int unsigned kind_tally[4];
  bit          calm_tx;

  contiguous_ring_frame_allocator #(.BUF_BYTES(BUF_BYTES)) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (req_kind),
    .body_len_i       (body_len_i),
    .sent_count_i     (sent_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_o       (accepted_o),
    .frame_start_o    (frame_start_o),
    .header_len_o     (header_len_o),
    .overrun_written_o(overrun_written_o),
    .overrun_start_o  (overrun_start_o),
    .lost_len_o       (lost_len_o),
    .run_start_o      (run_start_o),
    .run_len_o        (run_len_o)
  );

  crfa_result_checker #(.BUF_BYTES(BUF_BYTES)) i_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (req_kind),
    .body_len_i       (body_len_i),
    .sent_count_i     (sent_count_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_i       (accepted_o),
    .frame_start_i    (frame_start_o),
    .header_len_i     (header_len_o),
    .overrun_written_i(overrun_written_o),
    .overrun_start_i  (overrun_start_o),
    .lost_len_i       (lost_len_o),
    .run_start_i      (run_start_o),
    .run_len_i        (run_len_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Offer one request; return at the edge where it is taken, valid left high.
  task automatic offer(input crfa_kind_e k, input int unsigned body,
                       input int unsigned sent);
    while (!calm_tx && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_kind     <= k;
    body_len_i   <= BODY_W'(body);
    sent_count_i <= BODY_W'(sent);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    kind_tally[k]++;
  endtask

  // Receiver: random stalls, one long hold-off, one calm window
  initial begin
    int unsigned rx_cycle;
    rx_cycle    = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle == HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else begin
        out_ready_i <= (rx_cycle >= CALM_FROM && rx_cycle < CALM_TO) ||
                       ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) results_seen <= results_seen + 1;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("contiguous_ring_frame_allocator_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    bit          heavy;
    crfa_kind_e  k;
    int unsigned body;
    int unsigned sent;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_kind     = KIND_QUERY;
    body_len_i   = '0;
    sent_count_i = '0;
    calm_tx      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Header size boundaries, overrun marker and its suppression
    offer(KIND_QUERY, 0, 0);
    offer(KIND_RESERVE, 0, 0);
    offer(KIND_RESERVE, 125, 0);
    offer(KIND_RESERVE, 126, 0);
    offer(KIND_RESERVE, 65535, 0);
    offer(KIND_RESERVE, 65536, 0);
    offer(KIND_RESERVE, BODY_MAX, 0);
    // Zero and oversized sent counts
    offer(KIND_SENT, 0, 0);
    offer(KIND_SENT, 0, BODY_MAX);
    // Fill toward the end, wrap the writer, then consume exactly up to the wrap point
    offer(KIND_RESERVE, 60000, 0);
    offer(KIND_RESERVE, 10000, 0);
    offer(KIND_QUERY, 0, 0);
    offer(KIND_SENT, 0, 60004);
    offer(KIND_QUERY, 0, 0);
    offer(KIND_DROP, 0, 0);
    offer(KIND_QUERY, 0, 0);
    offer(KIND_RESERVE, BODY_MAX, 0);
    offer(KIND_RESERVE, 200, 0);
    offer(KIND_SENT, 0, 3);
    offer(KIND_DROP, 0, 0);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      calm_tx = (n >= 600 && n < 900);
      // Drain all results once before continuing
      if (n == 1200) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      // Alternate producer-heavy and consumer-heavy stretches
      heavy = ((n / 150) % 2) == 1;
      pick  = $urandom_range(99);
      if (heavy) begin
        k = (pick < 40) ? KIND_RESERVE : (pick < 50) ? KIND_QUERY :
            (pick < 97) ? KIND_SENT : KIND_DROP;
      end else begin
        k = (pick < 60) ? KIND_RESERVE : (pick < 72) ? KIND_QUERY :
            (pick < 98) ? KIND_SENT : KIND_DROP;
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        body = $urandom_range(SMALL_LIMIT - 1);
      end else if (pick < 45) begin
        case ($urandom_range(4))
          0: body = SMALL_LIMIT - 1;
          1: body = SMALL_LIMIT;
          2: body = MEDIUM_LIMIT - 1;
          3: body = MEDIUM_LIMIT;
          default: body = BODY_MAX;
        endcase
      end else if (pick < 80) begin
        body = $urandom_range(16383, SMALL_LIMIT);
      end else if (pick < 92) begin
        body = $urandom_range(MEDIUM_LIMIT - 1, 16384);
      end else begin
        body = $urandom_range(BODY_MAX, MEDIUM_LIMIT);
      end
      pick = $urandom_range(99);
      sent = (pick < 10) ? 0 : (pick < 20) ? BODY_MAX : $urandom_range(40000);
      offer(k, body, sent);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("requests: %0d reserve, %0d query, %0d sent, %0d drop; %0d results compared",
             kind_tally[KIND_RESERVE], kind_tally[KIND_QUERY], kind_tally[KIND_SENT],
             kind_tally[KIND_DROP], results_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("contiguous_ring_frame_allocator_tb: clean");
    end else begin
      $display("contiguous_ring_frame_allocator_tb: errors");
    end
    $finish;
  end

endmodule
